// ===== hw/rtl/circular_queue_fifo_defines.svh =====
// Assertion helpers shared by the queue's RTL files.
`ifndef CIRCULAR_QUEUE_FIFO_DEFINES_SVH
`define CIRCULAR_QUEUE_FIFO_DEFINES_SVH

// A property checked on every rising clock edge outside reset.
`define CQF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// An implication checked on every rising clock edge outside reset.
`define CQF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// An implication whose consequent is checked in the cycle after the antecedent.
`define CQF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/cqf_pkg.sv =====
package cqf_pkg;

  localparam int DEPTH_DEFAULT      = 16;
  localparam int DATA_WIDTH_DEFAULT = 32;

  localparam int          CAP_W     = 5;
  localparam logic [4:0]  CAP_RESET = 5'd16;
  localparam int          KIND_W    = 2;
  localparam int          STATUS_W  = 2;
  localparam int          OUT_W     = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_DUMP   = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_POP  = 2'd1,
    S_DUMP = 2'd2
  } state_e;

  typedef struct packed {
    logic    push;
    logic    pop;
    logic    dump_start;
    logic    dump_next;
    logic    out_load;
    logic    out_from_mem;
    status_e out_status;
    logic    out_last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic dump_more;
  } stat_t;

endpackage

// ===== hw/rtl/cqf_ctrl.sv =====
`include "circular_queue_fifo_defines.svh"

module cqf_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [cqf_pkg::KIND_W-1:0]    kind_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  cqf_pkg::stat_t                stat_i,
  output cqf_pkg::cmd_t                 cmd_o
);

  cqf_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            slot_free;
  logic            in_fire;

  // The result register can take a new result when empty or being drained.
  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == cqf_pkg::S_IDLE) && slot_free;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      cqf_pkg::S_IDLE: begin
        if (in_fire) begin
          case (cqf_pkg::kind_e'(kind_i))
            cqf_pkg::KIND_REMOVE: if (!stat_i.empty) state_d = cqf_pkg::S_POP;
            cqf_pkg::KIND_DUMP:   if (!stat_i.empty) state_d = cqf_pkg::S_DUMP;
            default:              state_d = cqf_pkg::S_IDLE;
          endcase
        end
      end
      cqf_pkg::S_POP: begin
        if (slot_free) state_d = cqf_pkg::S_IDLE;
      end
      cqf_pkg::S_DUMP: begin
        if (slot_free && !stat_i.dump_more) state_d = cqf_pkg::S_IDLE;
      end
      default: state_d = cqf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.out_status = cqf_pkg::ST_OK;
    case (state_q)
      cqf_pkg::S_IDLE: begin
        if (in_fire) begin
          case (cqf_pkg::kind_e'(kind_i))
            cqf_pkg::KIND_INSERT: begin
              cmd_o.out_load   = 1'b1;
              cmd_o.out_last   = 1'b1;
              cmd_o.push       = !stat_i.full;
              cmd_o.out_status = stat_i.full ? cqf_pkg::ST_OVERFLOW : cqf_pkg::ST_OK;
            end
            cqf_pkg::KIND_REMOVE: begin
              if (stat_i.empty) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_last   = 1'b1;
                cmd_o.out_status = cqf_pkg::ST_EMPTY;
              end else begin
                cmd_o.pop = 1'b1;
              end
            end
            cqf_pkg::KIND_DUMP: begin
              if (stat_i.empty) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_last   = 1'b1;
                cmd_o.out_status = cqf_pkg::ST_EMPTY;
              end else begin
                cmd_o.dump_start = 1'b1;
              end
            end
            default: cmd_o = cmd_o;
          endcase
        end
      end
      cqf_pkg::S_POP: begin
        if (slot_free) begin
          cmd_o.out_load     = 1'b1;
          cmd_o.out_from_mem = 1'b1;
          cmd_o.out_last     = 1'b1;
        end
      end
      cqf_pkg::S_DUMP: begin
        if (slot_free) begin
          cmd_o.out_load     = 1'b1;
          cmd_o.out_from_mem = 1'b1;
          cmd_o.out_last     = !stat_i.dump_more;
          // Fetch the next entry while this one moves into the result register.
          cmd_o.dump_next    = stat_i.dump_more;
        end
      end
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cqf_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `CQF_ASSERT_IMPL(a_load_into_free_slot, cmd_o.out_load, !out_valid_q || out_ready_i, "result overwritten before its transaction")
  `CQF_ASSERT_NEXT(a_read_then_deliver, cmd_o.pop || cmd_o.dump_start || cmd_o.dump_next, state_q == cqf_pkg::S_POP || state_q == cqf_pkg::S_DUMP, "memory read issued with no state to deliver it")
  `CQF_ASSERT(a_single_queue_op, !(cmd_o.push && (cmd_o.pop || cmd_o.dump_start)), "insert and read issued together")

endmodule

// ===== hw/rtl/cqf_dpath.sv =====
`include "circular_queue_fifo_defines.svh"

module cqf_dpath #(
  parameter int DEPTH      = cqf_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = cqf_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cqf_pkg::CAP_W-1:0]         cfg_data_i,
  input  logic signed [cqf_pkg::OUT_W-1:0]  value_i,
  input  cqf_pkg::cmd_t                     cmd_i,
  output cqf_pkg::stat_t                    stat_o,
  output logic [cqf_pkg::STATUS_W-1:0]      status_o,
  output logic signed [cqf_pkg::OUT_W-1:0]  data_o,
  output logic                              last_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int OW = $clog2(DEPTH + 1);
  localparam int LW = (OW > cqf_pkg::CAP_W) ? OW : cqf_pkg::CAP_W;

  logic [cqf_pkg::CAP_W-1:0]       cap_q;
  logic [PW-1:0]                   rp_q, rp_d, wp_q, wp_d, dptr_q, dptr_d;
  logic [OW-1:0]                   occ_q, occ_d, drem_q, drem_d;
  logic [LW-1:0]                   cap_ext, depth_ext, limit;
  logic [PW-1:0]                   raddr;
  logic                            rd_en;
  logic signed [DATA_WIDTH-1:0]    wdata;
  logic signed [DATA_WIDTH-1:0]    mem_q [DEPTH];
  logic signed [DATA_WIDTH-1:0]    rd_data_q;
  logic [cqf_pkg::STATUS_W-1:0]    status_q;
  logic signed [cqf_pkg::OUT_W-1:0] data_q;
  logic                            last_q;

  function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  // A capacity above the storage depth saturates to the depth.
  assign cap_ext   = LW'(cap_q);
  assign depth_ext = LW'(DEPTH);
  assign limit     = (cap_ext > depth_ext) ? depth_ext : cap_ext;

  assign stat_o.full      = LW'(occ_q) >= limit;
  assign stat_o.empty     = (occ_q == '0);
  assign stat_o.dump_more = (drem_q != '0);

  // Size casts sign-extend or truncate between the port and storage widths.
  assign wdata = DATA_WIDTH'(value_i);
  assign rd_en = cmd_i.pop || cmd_i.dump_start || cmd_i.dump_next;
  assign raddr = cmd_i.dump_next ? dptr_q : rp_q;

  always_comb begin
    rp_d   = rp_q;
    wp_d   = wp_q;
    occ_d  = occ_q;
    dptr_d = dptr_q;
    drem_d = drem_q;
    if (cmd_i.push) begin
      wp_d  = advance(wp_q);
      occ_d = occ_q + OW'(1);
    end
    if (cmd_i.pop) begin
      rp_d  = advance(rp_q);
      occ_d = occ_q - OW'(1);
    end
    if (cmd_i.dump_start) begin
      dptr_d = advance(rp_q);
      drem_d = occ_q - OW'(1);
    end
    if (cmd_i.dump_next) begin
      dptr_d = advance(dptr_q);
      drem_d = drem_q - OW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= cqf_pkg::CAP_RESET;
      rp_q   <= '0;
      wp_q   <= '0;
      occ_q  <= '0;
      dptr_q <= '0;
      drem_q <= '0;
    end else begin
      if (cfg_we_i) cap_q <= cfg_data_i;
      rp_q   <= rp_d;
      wp_q   <= wp_d;
      occ_q  <= occ_d;
      dptr_q <= dptr_d;
      drem_q <= drem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) mem_q[wp_q] <= wdata;
    if (rd_en) rd_data_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_q <= cmd_i.out_status;
      data_q   <= cmd_i.out_from_mem ? cqf_pkg::OUT_W'(rd_data_q) : '0;
      last_q   <= cmd_i.out_last;
    end
  end

  assign status_o = status_q;
  assign data_o   = data_q;
  assign last_o   = last_q;

  `CQF_ASSERT(a_occ_bounded, occ_q <= OW'(DEPTH), "occupancy beyond storage depth")

endmodule

// ===== hw/rtl/circular_queue_fifo.sv =====
// Ring-buffer queue of signed words with a programmable capacity.
// Input channel (in_valid_i/in_ready_o) carries one operation per transaction:
// kind_i insert stores value_i, remove returns the oldest word, dump streams
// every held word oldest first without removing any.
// Output channel (out_valid_o/out_ready_i) returns status_o, data_o and
// last_o; last_o marks the final result of an operation.
// The configuration channel (cfg_valid_i/cfg_ready_o) writes the capacity and
// is always ready; write it only while the queue is idle.
// Insert, and a remove or dump on an empty queue, load the result register on
// acceptance, so the result is valid the cycle after acceptance. Remove passes
// the registered storage read, then the result register once that is free.
// Dump gives one result per cycle after the first read while results are taken.
// A new operation is accepted while an earlier result still waits, so long
// as that result is taken in the same cycle; if the receiver stalls, the
// result holds and input acceptance stops.
// Reset empties the queue and sets the capacity to 16; storage contents are
// not cleared.
module circular_queue_fifo #(
  parameter int DEPTH      = cqf_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = cqf_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cqf_pkg::CAP_W-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [cqf_pkg::KIND_W-1:0]        kind_i,
  input  logic signed [cqf_pkg::OUT_W-1:0]  value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [cqf_pkg::STATUS_W-1:0]      status_o,
  output logic signed [cqf_pkg::OUT_W-1:0]  data_o,
  output logic                              last_o
);

  cqf_pkg::cmd_t  cmd;
  cqf_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  cqf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  cqf_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .value_i    (value_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .status_o   (status_o),
    .data_o     (data_o),
    .last_o     (last_o)
  );

endmodule

// ===== verif/queue_result_checker.sv =====
`timescale 1ns / 1ps

// Watches the configuration, operation and result channels of the queue,
// keeps its own copy of the queue contents and flags every result that differs
// from the predicted one.
module queue_result_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [cqf_pkg::CAP_W-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic [cqf_pkg::KIND_W-1:0]        kind_i,
  input  logic [cqf_pkg::OUT_W-1:0]         value_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic [cqf_pkg::STATUS_W-1:0]      status_i,
  input  logic [cqf_pkg::OUT_W-1:0]         data_i,
  input  logic                              last_i,
  output int                                error_count_o,
  output int                                outstanding_o,
  output int                                results_seen_o
);
  import cqf_pkg::*;

  localparam int DEPTH       = DEPTH_DEFAULT;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    status_e          status;
    logic [OUT_W-1:0] data;
    logic             last;
  } queue_result_t;

  logic [OUT_W-1:0] slots [DEPTH];
  int               head;
  int               tail;
  int               held;
  logic [CAP_W-1:0] capacity;
  queue_result_t    awaited [$];
  int               errors;
  int               seen;

  initial begin
    errors         = 0;
    seen           = 0;
    error_count_o  = 0;
    outstanding_o  = 0;
    results_seen_o = 0;
  end

  function automatic int step_ptr(input int p);
    return (p == DEPTH - 1) ? 0 : p + 1;
  endfunction

  function automatic void expect_result(input status_e st, input logic [OUT_W-1:0] word,
                                        input logic fin);
    queue_result_t r;
    r.status = st;
    r.data   = word;
    r.last   = fin;
    awaited.push_back(r);
  endfunction

  // Updates the queue copy for one operation and queues the results it causes.
  function automatic void apply_queue_op(input logic [KIND_W-1:0] op,
                                         input logic [OUT_W-1:0] word);
    int room;
    int p;
    room = (capacity > DEPTH) ? DEPTH : int'(capacity);
    p    = head;
    case (op)
      KIND_INSERT: begin
        if (held >= room) begin
          expect_result(ST_OVERFLOW, '0, 1'b1);
        end else begin
          slots[tail] = word;
          tail        = step_ptr(tail);
          held++;
          expect_result(ST_OK, '0, 1'b1);
        end
      end
      KIND_REMOVE: begin
        if (held == 0) begin
          expect_result(ST_EMPTY, '0, 1'b1);
        end else begin
          expect_result(ST_OK, slots[head], 1'b1);
          head = step_ptr(head);
          held--;
        end
      end
      KIND_DUMP: begin
        if (held == 0) begin
          expect_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int k = 0; k < held; k++) begin
            expect_result(ST_OK, slots[p], k == held - 1);
            p = step_ptr(p);
          end
        end
      end
      default: begin
        // The unused kind is dropped without a result.
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    queue_result_t want;
    if (!rst_ni) begin
      head     = 0;
      tail     = 0;
      held     = 0;
      capacity = CAP_RESET;
      awaited.delete();
      outstanding_o <= 0;
    end else begin
      // A result never belongs to an operation accepted at the same edge.
      if (out_valid_i && out_ready_i) begin
        seen++;
        if (awaited.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("%0t: result with no transaction awaiting it: status %0d data %h last %0d",
                     $realtime, status_i, data_i, last_i);
          end
        end else begin
          want = awaited.pop_front();
          if (want.status != status_i || want.data != data_i || want.last != last_i) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
              $display("%0t: result mismatch: expected status %0d data %h last %0d, got status %0d data %h last %0d",
                       $realtime, want.status, want.data, want.last,
                       status_i, data_i, last_i);
            end
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        capacity = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) begin
        apply_queue_op(kind_i, value_i);
      end
      outstanding_o  <= awaited.size();
      error_count_o  <= errors;
      results_seen_o <= seen;
    end
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import cqf_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED   = 2'd3;
  // Idle time after the last awaited result, so a stray result shows up before the next phase.
  localparam int                SETTLE_CYCLES = 40;
  localparam int                RANDOM_BLOCK  = 18;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CAP_W-1:0]      cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [KIND_W-1:0]     kind_i      = '0;
  logic [OUT_W-1:0]      value_i     = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [STATUS_W-1:0]   status_o;
  logic [OUT_W-1:0]      data_o;
  logic                  last_o;

  int tx_gap_pct   = 18;
  int rx_stall_pct = 82;
  int error_count;
  int outstanding;
  int results_seen;
  int n_insert     = 0;
  int n_remove     = 0;
  int n_dump       = 0;
  int n_unused     = 0;
  int n_settings   = 0;

  circular_queue_fifo dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .data_o      (data_o),
    .last_o      (last_o)
  );

  queue_result_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .kind_i         (kind_i),
    .value_i        (value_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_i       (status_o),
    .data_i         (data_o),
    .last_i         (last_o),
    .error_count_o  (error_count),
    .outstanding_o  (outstanding),
    .results_seen_o (results_seen)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d results still awaited", outstanding);
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_op(input logic [KIND_W-1:0] op, input logic [OUT_W-1:0] word);
    while ($urandom_range(99) < tx_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= op;
    value_i    <= word;
    do @(posedge clk_i); while (!in_ready_o);
    if (op == KIND_INSERT) begin
      n_insert++;
    end else if (op == KIND_REMOVE) begin
      n_remove++;
    end else if (op == KIND_DUMP) begin
      n_dump++;
    end else begin
      n_unused++;
    end
  endtask

  // Drops valid, waits until every predicted result has been taken, then idles for the settle time.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [OUT_W-1:0] pick_word();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Fills for the first two thirds of the block, then leans toward draining.
  task automatic run_random_ops(input int count);
    int   done;
    int   r;
    logic fill;
    done = 0;
    while (done < count) begin
      r    = $urandom_range(99);
      fill = (done < (count * 2) / 3);
      if (r < 4) begin
        send_op(KIND_UNUSED, $urandom);
      end else begin
        if (r < 14) begin
          send_op(KIND_DUMP, $urandom);
        end else if (r < (fill ? 82 : 40)) begin
          send_op(KIND_INSERT, pick_word());
        end else begin
          send_op(KIND_REMOVE, $urandom);
        end
        done++;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty queue, extreme words, the unused kind, then a dump and a remove.
    send_op(KIND_DUMP, 32'h0);
    send_op(KIND_REMOVE, 32'h0);
    send_op(KIND_INSERT, 32'h7fff_ffff);
    send_op(KIND_INSERT, 32'h8000_0000);
    send_op(KIND_INSERT, 32'h0000_0000);
    send_op(KIND_INSERT, 32'hffff_ffff);
    send_op(KIND_UNUSED, 32'h1234_5678);
    send_op(KIND_DUMP, 32'h0);
    send_op(KIND_REMOVE, 32'h0);

    // Capacity lowered below the three held entries.
    set_capacity(5'd2);
    send_op(KIND_INSERT, 32'h5555_5555);
    send_op(KIND_REMOVE, 32'h0);
    send_op(KIND_INSERT, 32'haaaa_aaaa);
    send_op(KIND_REMOVE, 32'h0);
    send_op(KIND_INSERT, 32'h0000_0001);
    send_op(KIND_DUMP, 32'h0);

    // With zero capacity every insert overflows while removes still drain.
    set_capacity(5'd0);
    send_op(KIND_INSERT, 32'hdead_beef);
    send_op(KIND_REMOVE, 32'h0);
    send_op(KIND_REMOVE, 32'h0);
    send_op(KIND_REMOVE, 32'h0);
    send_op(KIND_DUMP, 32'h0);

    set_capacity(5'd31);
    run_random_ops(RANDOM_BLOCK);
    set_capacity(5'd1);
    run_random_ops(RANDOM_BLOCK);

    tx_gap_pct   = 82;
    rx_stall_pct = 18;
    set_capacity(5'd5);
    run_random_ops(RANDOM_BLOCK);
    set_capacity(5'd16);
    run_random_ops(RANDOM_BLOCK);

    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    set_capacity(5'd17);
    run_random_ops(RANDOM_BLOCK);
    set_capacity(5'd3);
    run_random_ops(RANDOM_BLOCK);

    wait_drained();

    $display("Covered %0d inserts, %0d removes, %0d dumps and %0d unused-kind transactions",
             n_insert, n_remove, n_dump, n_unused);
    $display("over %0d capacity writes; %0d results compared, %0d errors, %0d still awaited",
             n_settings, results_seen, error_count, outstanding);
    if (error_count == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
